// File: hdl/htks_pkg.sv
// htks_pkg: shared types, codes and constants of the hybrid key-table search.
// Used by every module of the block; depends on nothing.
package htks_pkg;

  localparam int KEY_BITS      = 48;    // width of a stored or sought key
  localparam int INDEX_W       = 10;    // width of a table position on the ports
  localparam int COUNT_W       = 11;    // width of the entry count register
  localparam int TABLE_DEPTH   = 1024;  // default table depth
  localparam int FRAC_BITS     = 16;    // fraction bits of the bisection bounds
  localparam int SMALL_LIST    = 4;     // below this many entries always scan
  localparam int SCAN_SPAN     = 10;    // bisection hands over to a scan below this span
  localparam int QUEUE_DEPTH   = 2;     // requests held between front and back
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = COUNT_W;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SORT_MODE   = 1'd1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic MODE_UNSORTED  = 1'b0;
  localparam logic MODE_ASCENDING = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [KEY_BITS-1:0] entry_key;
    logic signed [KEY_BITS-1:0] search_key;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } out_t;

  // Kind of work the back end has to do for one request
  typedef enum logic [1:0] {
    OP_WRITE,   // store a key
    OP_MISS,    // empty table: answer not found at once
    OP_SCAN,    // linear scan over 0..count-1
    OP_BISECT   // ascending bisection, then a short scan if no probe hits
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [INDEX_W-1:0]         index;
    logic signed [KEY_BITS-1:0] key;
    logic [COUNT_W-1:0]         count;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BIS_PROBE,
    BK_BIS_CMP,
    BK_SCAN
  } back_state_t;

endpackage

// File: hdl/htks_front.sv
// htks_front: configuration registers and request classification.
// Depends on htks_pkg; feeds htks_queue.
module htks_front #(
  parameter int TABLE_DEPTH = htks_pkg::TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [htks_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [htks_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               start,
  input  htks_pkg::in_t                      in_data,
  input  logic                               q_full,
  output logic                               push,
  output htks_pkg::cmd_t                     push_cmd
);

  logic [htks_pkg::COUNT_W-1:0] count_r;
  logic                         sort_r;
  logic [htks_pkg::COUNT_W-1:0] count_eff;
  logic                         drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sort_r  <= htks_pkg::MODE_UNSORTED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htks_pkg::REG_ENTRY_COUNT: count_r <= cfg_data;
        htks_pkg::REG_SORT_MODE:   sort_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the count to the table depth
  always_comb begin
    if (32'(count_r) > 32'(TABLE_DEPTH)) begin
      count_eff = htks_pkg::COUNT_W'(TABLE_DEPTH);
    end else begin
      count_eff = count_r;
    end
  end

  always_comb begin
    drop           = 1'b0;
    push_cmd.index = in_data.entry_index;
    push_cmd.count = count_eff;
    if (in_data.func == htks_pkg::FUNC_WRITE) begin
      push_cmd.op  = htks_pkg::OP_WRITE;
      push_cmd.key = in_data.entry_key;
      // drop writes beyond the table
      drop         = !(32'(in_data.entry_index) < 32'(TABLE_DEPTH));
    end else begin
      push_cmd.key = in_data.search_key;
      priority if (count_eff == '0) begin
        push_cmd.op = htks_pkg::OP_MISS;
      end else if (sort_r == htks_pkg::MODE_UNSORTED ||
                   count_eff < htks_pkg::COUNT_W'(htks_pkg::SMALL_LIST)) begin
        push_cmd.op = htks_pkg::OP_SCAN;
      end else begin
        push_cmd.op = htks_pkg::OP_BISECT;
      end
    end
  end

  assign push = start && !q_full && !drop;

endmodule

// File: hdl/htks_queue.sv
// htks_queue: short first-in first-out queue of classified requests.
// Depends on htks_pkg; sits between htks_front and htks_back.
module htks_queue #(
  parameter int DEPTH = htks_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  htks_pkg::cmd_t push_cmd,
  input  logic           pop,
  output htks_pkg::cmd_t pop_cmd,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  htks_pkg::cmd_t store_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OW-1:0]  fill_r,   fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd = store_r[rd_ptr_r];
  assign empty   = (fill_r == '0);
  assign full    = (fill_r == OW'(DEPTH));

endmodule

// File: hdl/htks_back.sv
// htks_back: key memory, bisection and linear scan sequencer, result register.
// Depends on htks_pkg; drains htks_queue.
module htks_back #(
  parameter int TABLE_DEPTH = htks_pkg::TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  htks_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  output htks_pkg::out_t out_data
);

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = htks_pkg::COUNT_W;
  localparam int FB   = htks_pkg::FRAC_BITS;
  localparam int FX_W = CW + FB;
  localparam int KB   = htks_pkg::KEY_BITS;

  logic signed [KB-1:0] mem [TABLE_DEPTH];

  htks_pkg::back_state_t state_r, state_nxt;

  logic [FX_W-1:0]      lo_r,  lo_nxt;
  logic [FX_W-1:0]      hi_r,  hi_nxt;
  logic [FX_W-1:0]      mid_r, mid_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [CW-1:0]        last_r, last_nxt;
  logic                 pend_r, pend_nxt;
  logic [CW-1:0]        pend_idx_r, pend_idx_nxt;
  logic signed [KB-1:0] key_r, key_nxt;
  logic signed [KB-1:0] rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  htks_pkg::out_t       out_r, out_nxt;

  logic [IW-1:0]        rd_addr;
  logic                 mem_we;

  logic [CW-1:0]        lo_i, hi_i, mid_i, cmp_i;
  logic [FX_W:0]        mid_sum;
  logic                 near;
  logic                 scan_hit;
  logic                 issue_ok;

  assign lo_i     = lo_r[FX_W-1:FB];
  assign hi_i     = hi_r[FX_W-1:FB];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_i    = mid_sum[FX_W:FB+1];
  assign cmp_i    = mid_r[FX_W-1:FB];
  assign near     = ({1'b0, hi_i} < ({1'b0, lo_i} + (CW + 1)'(htks_pkg::SCAN_SPAN)));
  assign scan_hit = pend_r && (rd_data_r == key_r);
  assign issue_ok = (ptr_r <= last_r);
  assign q_pop    = (state_r == htks_pkg::BK_IDLE) && !q_empty;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htks_pkg::BK_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            htks_pkg::OP_SCAN:   state_nxt = htks_pkg::BK_SCAN;
            htks_pkg::OP_BISECT: state_nxt = htks_pkg::BK_BIS_PROBE;
            default:             state_nxt = htks_pkg::BK_IDLE;
          endcase
        end
      end
      htks_pkg::BK_BIS_PROBE: begin
        state_nxt = near ? htks_pkg::BK_SCAN : htks_pkg::BK_BIS_CMP;
      end
      htks_pkg::BK_BIS_CMP: begin
        state_nxt = (rd_data_r == key_r) ? htks_pkg::BK_IDLE : htks_pkg::BK_BIS_PROBE;
      end
      htks_pkg::BK_SCAN: begin
        if (scan_hit || !issue_ok) begin
          state_nxt = htks_pkg::BK_IDLE;
        end
      end
      default: state_nxt = htks_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = IW'(ptr_r);
    mem_we        = 1'b0;
    unique case (state_r)
      htks_pkg::BK_IDLE: begin
        if (q_pop) begin
          key_nxt  = q_cmd.key;
          ptr_nxt  = '0;
          last_nxt = q_cmd.count - 1'b1;
          lo_nxt   = '0;
          hi_nxt   = {q_cmd.count - 1'b1, FB'(0)};
          unique case (q_cmd.op)
            htks_pkg::OP_WRITE: mem_we = 1'b1;
            htks_pkg::OP_MISS: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
            default: ;
          endcase
        end
      end
      htks_pkg::BK_BIS_PROBE: begin
        if (near) begin
          // hand the remaining span over to the scan
          ptr_nxt  = lo_i;
          last_nxt = hi_i;
        end else begin
          mid_nxt = mid_sum[FX_W:1];
          rd_addr = IW'(mid_i);
        end
      end
      htks_pkg::BK_BIS_CMP: begin
        if (rd_data_r == key_r) begin
          out_valid_nxt = 1'b1;
          out_nxt.found = 1'b1;
          out_nxt.match_index = htks_pkg::INDEX_W'(cmp_i);
        end else if (key_r < rd_data_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r;
        end
      end
      htks_pkg::BK_SCAN: begin
        if (scan_hit) begin
          out_valid_nxt = 1'b1;
          out_nxt.found = 1'b1;
          out_nxt.match_index = htks_pkg::INDEX_W'(pend_idx_r);
        end else if (!issue_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
        end else begin
          // issue one read a cycle, compare it the cycle after
          rd_addr      = IW'(ptr_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r;
          ptr_nxt      = ptr_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htks_pkg::BK_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    ptr_r      <= ptr_nxt;
    last_r     <= last_nxt;
    pend_idx_r <= pend_idx_nxt;
    key_r      <= key_nxt;
    out_r      <= out_nxt;
  end

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IW'(q_cmd.index)] <= q_cmd.key;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/hybrid_table_key_search.sv
// hybrid_table_key_search: top level of the key-table search block.
// Depends on htks_pkg, htks_front, htks_queue and htks_back.
//
//  channel  | handshake          | payload               | direction
//  ---------+--------------------+-----------------------+----------
//  request  | start / busy       | in_data  (in_t)       | in
//  result   | out_valid strobe   | out_data (out_t)      | out
//  config   | cfg_we             | cfg_index, cfg_data   | in
//
// A request is taken when start is high and busy is low; busy rises only when
// the request queue is full. The back end stores a write request from its idle
// state. An unsorted search (or one over fewer than 4 entries) reads one entry
// a cycle; an ascending search has a probe state and a compare state for each
// bisection probe, then scans at most 10 entries unless a probe hits. The
// single read port of the key memory sets this pace. Reset clears the queue
// and sequencer; the key memory is not cleared. Results are strobed for one
// cycle and cannot be held off.
module hybrid_table_key_search #(
  parameter int TABLE_DEPTH = htks_pkg::TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  htks_pkg::in_t                    in_data,
  output logic                             out_valid,
  output htks_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [htks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [htks_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           push;
  htks_pkg::cmd_t push_cmd;
  logic           pop;
  htks_pkg::cmd_t pop_cmd;
  logic           q_empty;
  logic           q_full;

  // Front: hold configuration, classify each request
  htks_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Queue: decouple acceptance from the long-running searches
  htks_queue #(
    .DEPTH (htks_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: execute writes and searches against the key memory
  htks_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = q_full;

endmodule

// File: hdl/htks_checker.sv
// htks_checker: port-level assertions for hybrid_table_key_search, with bind.
// Depends on htks_pkg; attaches to the top level.
module htks_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input htks_pkg::in_t                    in_data,
  input logic                             out_valid,
  input htks_pkg::out_t                   out_data,
  input logic                             cfg_we,
  input logic [htks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [htks_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [htks_pkg::CFG_DATA_W-1:0] count_r;

  // Mirror the entry count as written on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we && cfg_index == htks_pkg::REG_ENTRY_COUNT) begin
      count_r <= cfg_data;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_index == '0)
    else $error("miss result with non-zero index");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> 32'(out_data.match_index) < 32'(count_r))
    else $error("hit index beyond entry count");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity straight after reset");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && !$past(busy))
    else $error("busy rose without an accepted request");

endmodule

bind hybrid_table_key_search htks_checker u_htks_checker (.*);

// File: tb/sv/htks_search_checker.sv
`timescale 1ns / 100ps
// htks_search_checker: watches the request, result and configuration ports of
// hybrid_table_key_search, predicts every search answer and compares it.
// Depends on htks_pkg only.
module htks_search_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  htks_pkg::in_t                        in_data,
  input  logic                                 out_valid,
  input  htks_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [htks_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [htks_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   errors,
  output int                                   pending
);

  logic signed [htks_pkg::KEY_BITS-1:0] stored_keys [htks_pkg::TABLE_DEPTH];
  logic [htks_pkg::COUNT_W-1:0]         entry_count;
  logic                                 sort_mode;
  htks_pkg::out_t                       search_answers [$];
  int                                   mismatches = 0;

  // First match in first..last, clipped to the table
  function automatic bit scan_keys(int unsigned first, int unsigned last,
                                   logic signed [htks_pkg::KEY_BITS-1:0] key,
                                   output int unsigned at);
    int unsigned n;
    at = 0;
    for (n = first; n <= last && n < htks_pkg::TABLE_DEPTH; n++) begin
      if (stored_keys[n] == key) begin
        at = n;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Bounds carry FRAC_BITS fraction bits; a probe uses the integer part of mid
  function automatic bit bisect_keys(int unsigned used,
                                     logic signed [htks_pkg::KEY_BITS-1:0] key,
                                     output int unsigned at);
    int unsigned lo, hi, lo_int, hi_int, mid, probe, step;
    lo = 0;
    hi = (used - 1) << htks_pkg::FRAC_BITS;
    at = 0;
    for (step = 0; step < used; step++) begin
      lo_int = lo >> htks_pkg::FRAC_BITS;
      hi_int = hi >> htks_pkg::FRAC_BITS;
      if (hi_int < lo_int + htks_pkg::SCAN_SPAN)
        return scan_keys(lo_int, hi_int, key, at);
      mid   = (lo + hi) >> 1;
      probe = mid >> htks_pkg::FRAC_BITS;
      if (probe >= htks_pkg::TABLE_DEPTH)
        return 1'b0;
      if (stored_keys[probe] == key) begin
        at = probe;
        return 1'b1;
      end
      if (key < stored_keys[probe])
        hi = mid;
      else
        lo = mid;
    end
    return 1'b0;
  endfunction

  function automatic htks_pkg::out_t search_table(
      logic signed [htks_pkg::KEY_BITS-1:0] key);
    int unsigned    used, at;
    bit             hit;
    htks_pkg::out_t answer;
    used = (entry_count > htks_pkg::TABLE_DEPTH) ? htks_pkg::TABLE_DEPTH : entry_count;
    at   = 0;
    if (used == 0)
      hit = 1'b0;
    else if (sort_mode == htks_pkg::MODE_UNSORTED || used < htks_pkg::SMALL_LIST)
      hit = scan_keys(0, used - 1, key, at);
    else
      hit = bisect_keys(used, key, at);
    answer.found       = hit;
    answer.match_index = hit ? at[htks_pkg::INDEX_W-1:0] : '0;
    return answer;
  endfunction

  always @(posedge clk) begin
    htks_pkg::out_t want;
    if (!rst_n) begin
      entry_count = '0;
      sort_mode   = htks_pkg::MODE_UNSORTED;
      search_answers.delete();
    end else begin
      // compare before taking this edge's request: no answer is that quick
      if (out_valid) begin
        if (search_answers.size() == 0) begin
          $error("result with no search outstanding: found=%0d match_index=%0d",
                 out_data.found, out_data.match_index);
          mismatches++;
        end else begin
          want = search_answers.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            mismatches++;
          end
          if (out_data.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d",
                   want.match_index, out_data.match_index);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          htks_pkg::REG_ENTRY_COUNT: entry_count = cfg_data[htks_pkg::COUNT_W-1:0];
          htks_pkg::REG_SORT_MODE:   sort_mode   = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_data.func == htks_pkg::FUNC_WRITE)
          stored_keys[in_data.entry_index] = in_data.entry_key;
        else
          search_answers.push_back(search_table(in_data.search_key));
      end
    end
    errors  <= mismatches;
    pending <= search_answers.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for hybrid_table_key_search.
// Depends on htks_pkg, the block itself and htks_search_checker.
module tb;

  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_REQUESTS = 560;
  // a few writes may still sit in the request queue once the last answer is in
  localparam int DRAIN_CYCLES    = 24;
  // a guard far above the slowest plausible run
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam int KB = htks_pkg::KEY_BITS;
  localparam int IW = htks_pkg::INDEX_W;
  localparam int DW = htks_pkg::CFG_DATA_W;
  localparam int TD = htks_pkg::TABLE_DEPTH;

  localparam logic signed [KB-1:0] KEY_MIN = {1'b1, {(KB-1){1'b0}}};
  localparam logic signed [KB-1:0] KEY_MAX = {1'b0, {(KB-1){1'b1}}};
  localparam longint KEY_MIN_L = -(longint'(1) << (KB - 1));
  localparam longint KEY_MAX_L = (longint'(1) << (KB - 1)) - 1;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  htks_pkg::in_t                    in_data;
  logic                             out_valid;
  htks_pkg::out_t                   out_data;
  logic                             cfg_we;
  logic [htks_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [DW-1:0]                    cfg_data;
  int                               errors;
  int                               pending;

  // what the table holds, so that searches can aim at keys that are present
  logic signed [KB-1:0] mirror_keys [TD];
  int unsigned          requests_sent = 0;
  int unsigned          gap_pct = 23;
  int unsigned          cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hybrid_table_key_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  htks_search_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic logic signed [KB-1:0] rand_key();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[KB-1:0];
  endfunction

  // Mostly keys that are in use, then near misses, noise, extremes and keys
  // that only live beyond the entry count
  function automatic logic signed [KB-1:0] probe_key(int unsigned n);
    logic signed [KB-1:0] key;
    key = rand_key();
    if (n == 0)
      return key;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: key = mirror_keys[$urandom_range(n - 1)];
      5, 6: begin
        key = mirror_keys[$urandom_range(n - 1)];
        if ($urandom_range(1) == 0)
          key = key + 48'sd1;
        else
          key = key - 48'sd1;
      end
      7: ;
      8: begin
        case ($urandom_range(3))
          0: key = KEY_MIN;
          1: key = KEY_MAX;
          2: key = '0;
          default: key = '1;
        endcase
      end
      default: begin
        if (n < TD)
          key = mirror_keys[$urandom_range(TD - 1, n)];
      end
    endcase
    return key;
  endfunction

  // Offer one request; hold it until the block takes it. Idle cycles come
  // first, each with probability gap_pct.
  task automatic send(htks_pkg::in_t req);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic store(logic [IW-1:0] idx, logic signed [KB-1:0] key);
    htks_pkg::in_t req;
    mirror_keys[idx] = key;
    req.func        = htks_pkg::FUNC_WRITE;
    req.entry_index = idx;
    req.entry_key   = key;
    req.search_key  = rand_key();
    send(req);
  endtask

  task automatic seek(logic signed [KB-1:0] key);
    htks_pkg::in_t req;
    req.func        = htks_pkg::FUNC_SEARCH;
    req.entry_index = IW'($urandom_range(TD - 1));
    req.entry_key   = rand_key();
    req.search_key  = key;
    send(req);
  endtask

  // Drop start and wait until every answer is in and the queue has drained
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned count, logic mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= htks_pkg::REG_ENTRY_COUNT;
    cfg_data  <= count[DW-1:0];
    @(posedge clk);
    cfg_index <= htks_pkg::REG_SORT_MODE;
    cfg_data  <= {{(DW-1){1'b0}}, mode};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Ascending keys from a negative start; a narrow stride gives runs of duplicates
  task automatic fill_sorted(int unsigned n);
    longint          key, stride;
    longint unsigned rnd;
    int unsigned     i;
    stride = ($urandom_range(2) == 0) ? longint'(2)
                                      : (longint'(1) << $urandom_range(16, 37));
    key = ($urandom_range(1) == 0) ? KEY_MIN_L : -longint'($urandom_range(1 << 30));
    for (i = 0; i < n; i++) begin
      if (i != 0) begin
        rnd = {$urandom, $urandom};
        key = key + longint'(rnd % longint'(stride + 1));
      end
      if (key > KEY_MAX_L || (i == n - 1 && $urandom_range(3) == 0))
        key = KEY_MAX_L;
      store(i[IW-1:0], key[KB-1:0]);
    end
  endtask

  task automatic fill_random(int unsigned n, bit narrow);
    logic signed [KB-1:0] key;
    int unsigned          i;
    for (i = 0; i < n; i++) begin
      key = rand_key();
      // narrow keys fall in -8..7, so duplicates are common
      if (narrow)
        key = key >>> (KB - 4);
      store(i[IW-1:0], key);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hybrid_table_key_search: mismatch");
    $finish;
  end

  initial begin
    int unsigned reg_count, hops, j, done, base, filled;
    int unsigned pick;
    logic        mode;

    foreach (mirror_keys[i])
      mirror_keys[i] = '0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= htks_pkg::REG_ENTRY_COUNT;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table straight after reset finds nothing
    seek(KEY_MAX);
    // extreme keys in the first entries, plus the last table position
    store(IW'(0), KEY_MIN);
    store(IW'(1), KEY_MAX);
    store(IW'(2), '0);
    store(IW'(3), '1);
    store(IW'(TD - 1), rand_key());
    // fewer than four entries: a scan even in ascending mode; -1 lies past it
    configure(3, htks_pkg::MODE_ASCENDING);
    seek(KEY_MIN);
    seek(KEY_MAX);
    seek('0);
    seek('1);
    configure(4, htks_pkg::MODE_UNSORTED);
    seek('1);
    seek(rand_key());
    // duplicate key: the first match wins
    store(IW'(2), KEY_MAX);
    seek(KEY_MAX);
    configure(4, htks_pkg::MODE_ASCENDING);
    seek('1);
    seek('0);

    // Counts at and beyond the table depth. Keys are chosen so that every
    // search ends on entries already written: the first bisection probe lands
    // on the middle entry, the second on the quarter entry, and an unsorted
    // scan for the key in entry 0 stops at once.
    store(IW'(TD / 2 - 1), 48'sd1000);
    store(IW'(TD / 4 - 1), -48'sd1000);
    configure((1 << DW) - 1, htks_pkg::MODE_ASCENDING);
    seek(48'sd1000);
    seek(-48'sd1000);
    configure(TD, htks_pkg::MODE_ASCENDING);
    seek(48'sd1000);
    configure(TD + 1, htks_pkg::MODE_UNSORTED);
    seek(KEY_MIN);

    // Random rounds. Entries 0..filled-1 are written; a larger count refills.
    filled = 4;
    base   = requests_sent;
    done   = 0;
    while (done < RANDOM_REQUESTS) begin
      if (done < RANDOM_REQUESTS / 3)
        gap_pct = 23;
      else if (done < 2 * RANDOM_REQUESTS / 3)
        gap_pct = 83;
      else
        gap_pct = 0;

      pick = $urandom_range(99);
      if (pick < 5)
        reg_count = 0;
      else if (pick < 15)
        reg_count = $urandom_range(1, 3);
      else if (pick < 40)
        reg_count = $urandom_range(4, 12);
      else if (pick < 80)
        reg_count = $urandom_range(13, 64);
      else
        reg_count = $urandom_range(65, 200);
      mode = 1'($urandom_range(1));
      configure(reg_count, mode);

      // refill most of the time; sorted when bisection is on
      if (reg_count > 0 && (reg_count > filled || $urandom_range(3) != 0)) begin
        if (mode == htks_pkg::MODE_ASCENDING)
          fill_sorted(reg_count);
        else
          fill_random(reg_count, 1'($urandom_range(1)));
        if (reg_count > filled)
          filled = reg_count;
      end

      hops = $urandom_range(3, 12);
      for (j = 0; j < hops; j++) begin
        // an odd write anywhere, which may break the ordering
        if ($urandom_range(6) == 0)
          store(IW'($urandom_range(TD - 1)), rand_key());
        else
          seek(probe_key(reg_count));
      end
      done = requests_sent - base;
    end

    settle();
    if (errors == 0)
      $display("hybrid_table_key_search: match");
    else
      $display("hybrid_table_key_search: mismatch");
    $finish;
  end

endmodule
